@@ hw/rtl/fbfl_pkg.sv @@
// Shared types and constants for the fixed-block free-list allocator.
// No dependencies; every other file in this block but fbfl_link_ram uses it.
package fbfl_pkg;

  localparam int unsigned MAX_BLOCKS_DEF = 1024;

  localparam int unsigned FUNC_W   = 1;
  localparam int unsigned SIZE_W   = 16;
  localparam int unsigned IDX_W    = 10;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned OFF_W    = 22;
  localparam int unsigned BSIZE_W  = 13;
  localparam int unsigned BCOUNT_W = 11;
  localparam int unsigned CNT_W    = 11;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 13;

  // The 10-bit index field caps the usable pool at this many blocks.
  localparam int unsigned IDX_SPAN = 1024;

  localparam logic [BSIZE_W-1:0]  BSIZE_RST  = 13'd64;
  localparam logic [BCOUNT_W-1:0] BCOUNT_RST = 11'd1024;

  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_TOO_BIG = 2'd1,
    STAT_EMPTY   = 2'd2
  } status_e;

  typedef enum logic {
    FSM_IDLE,
    FSM_POP
  } fsm_e;

endpackage

@@ hw/rtl/fbfl_req_if.sv @@
// Request channel of the allocator: valid/ready plus the request item.
// Depends on fbfl_pkg for field widths.
interface fbfl_req_if;
  logic                             valid;
  logic                             ready;
  logic [fbfl_pkg::FUNC_W-1:0]      func;
  logic [fbfl_pkg::SIZE_W-1:0]      request_size;
  logic [fbfl_pkg::IDX_W-1:0]       free_block_index;

  modport source (output valid, func, request_size, free_block_index, input ready);
  modport sink   (input valid, func, request_size, free_block_index, output ready);
endinterface

@@ hw/rtl/fbfl_rsp_if.sv @@
// Result channel of the allocator: valid/ready plus the result item.
// Depends on fbfl_pkg for field widths.
interface fbfl_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [fbfl_pkg::STAT_W-1:0]      status;
  logic [fbfl_pkg::IDX_W-1:0]       block_index;
  logic [fbfl_pkg::OFF_W-1:0]       byte_offset;

  modport source (output valid, status, block_index, byte_offset, input ready);
  modport sink   (input valid, status, block_index, byte_offset, output ready);
endinterface

@@ hw/rtl/fixed_block_free_list_allocator.sv @@
// Fixed-size block pool allocator. An allocate returns a block index and its byte offset
// (index times block size, low 22 bits); freed blocks come back last-freed-first from a
// linked free list kept in a one-port-write, one-port-read link memory, and after those
// the never-used blocks follow in ascending order. A free, a rejected or empty allocate and
// an allocate of a never-used block are each handled in the idle state alone, so they
// stream at one item per cycle while results are taken. An allocate that pops the free
// list also passes the pop state: the link of the head block is read from the link memory,
// whose read data is registered, before the head can move; no new item is accepted meanwhile.
// A result passes a result stage and then an output register before it can be taken, and
// one result may wait at the output while the next item is accepted.
// The link memory needs no clearing after reset; only entries that were freed are ever read.
// Depends on fbfl_pkg, fbfl_req_if, fbfl_rsp_if and fbfl_link_ram.
module fixed_block_free_list_allocator #(
  parameter int unsigned MAX_BLOCKS = fbfl_pkg::MAX_BLOCKS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [fbfl_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [fbfl_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  fbfl_req_if.sink                             req_i,
  fbfl_rsp_if.source                           rsp_o
);

  localparam int unsigned DEPTH  = (MAX_BLOCKS < fbfl_pkg::IDX_SPAN) ?
                                   MAX_BLOCKS : fbfl_pkg::IDX_SPAN;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam logic [fbfl_pkg::CNT_W-1:0] DEPTH_CNT = fbfl_pkg::CNT_W'(DEPTH);
  localparam logic [fbfl_pkg::CNT_W-1:0] CNT_SAT   = '1;

  // configuration
  logic [fbfl_pkg::BSIZE_W-1:0]  bsize_q, bsize_d;
  logic [fbfl_pkg::BCOUNT_W-1:0] bcount_q, bcount_d;

  // control state
  fbfl_pkg::fsm_e                state_q, state_d;
  logic [ADDR_W-1:0]             head_q, head_d;
  logic [fbfl_pkg::CNT_W-1:0]    count_q, count_d;
  logic [fbfl_pkg::CNT_W-1:0]    fresh_q, fresh_d;
  logic                          pend_valid_q, pend_valid_d;
  logic                          out_valid_q, out_valid_d;

  // payload
  fbfl_pkg::status_e             pend_stat_q, pend_stat_d;
  logic [fbfl_pkg::IDX_W-1:0]    pend_idx_q, pend_idx_d;
  logic [fbfl_pkg::STAT_W-1:0]   out_stat_q;
  logic [fbfl_pkg::IDX_W-1:0]    out_idx_q;
  logic [fbfl_pkg::OFF_W-1:0]    out_off_q;

  logic                          pend_move;
  logic                          req_ready;
  logic                          accept;
  logic                          fidx_ok;
  logic [fbfl_pkg::CNT_W-1:0]    fresh_lim;
  logic [fbfl_pkg::IDX_W+fbfl_pkg::BSIZE_W-1:0] prod;

  logic                          ram_we;
  logic [ADDR_W-1:0]             ram_waddr;
  logic [ADDR_W-1:0]             ram_wdata;
  logic                          ram_re;
  logic [ADDR_W-1:0]             ram_raddr;
  logic [ADDR_W-1:0]             ram_rdata;

  fbfl_link_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    bsize_d  = bsize_q;
    bcount_d = bcount_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fbfl_pkg::CFG_BLOCK_SIZE: begin
          bsize_d = cfg_data_i;
        end
        fbfl_pkg::CFG_BLOCK_COUNT: begin
          bcount_d = cfg_data_i[fbfl_pkg::BCOUNT_W-1:0];
        end
      endcase
    end
  end

  assign fresh_lim = (bcount_q < DEPTH_CNT) ? bcount_q : DEPTH_CNT;
  assign fidx_ok   = ({1'b0, req_i.free_block_index} < DEPTH_CNT);

  // result stage drains into the output register when that is free or being taken
  assign pend_move = pend_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_ready = (state_q == fbfl_pkg::FSM_IDLE) && (!pend_valid_q || pend_move);
  assign accept    = req_i.valid && req_ready;

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    count_d      = count_q;
    fresh_d      = fresh_q;
    pend_valid_d = pend_valid_q && !pend_move;
    pend_stat_d  = pend_stat_q;
    pend_idx_d   = pend_idx_q;
    ram_we       = 1'b0;
    ram_waddr    = req_i.free_block_index[ADDR_W-1:0];
    ram_wdata    = head_q;
    ram_re       = 1'b0;
    ram_raddr    = head_q;

    unique case (state_q)
      fbfl_pkg::FSM_IDLE: begin
        if (accept) begin
          if (req_i.func == fbfl_pkg::FUNC_FREE) begin
            pend_valid_d = 1'b1;
            pend_stat_d  = fbfl_pkg::STAT_OK;
            pend_idx_d   = req_i.free_block_index;
            // push onto the list head; out-of-range indexes leave the list alone
            if (fidx_ok) begin
              ram_we = 1'b1;
              head_d = req_i.free_block_index[ADDR_W-1:0];
              if (count_q != CNT_SAT) begin
                count_d = count_q + 1'b1;
              end
            end
          end else if (req_i.request_size > {3'b000, bsize_q}) begin
            pend_valid_d = 1'b1;
            pend_stat_d  = fbfl_pkg::STAT_TOO_BIG;
            pend_idx_d   = '0;
          end else if (count_q != '0) begin
            // fetch the link of the head block; finish next cycle
            ram_re  = 1'b1;
            state_d = fbfl_pkg::FSM_POP;
          end else if (fresh_q < fresh_lim) begin
            pend_valid_d = 1'b1;
            pend_stat_d  = fbfl_pkg::STAT_OK;
            pend_idx_d   = fresh_q[fbfl_pkg::IDX_W-1:0];
            fresh_d      = fresh_q + 1'b1;
          end else begin
            pend_valid_d = 1'b1;
            pend_stat_d  = fbfl_pkg::STAT_EMPTY;
            pend_idx_d   = '0;
          end
        end
      end
      fbfl_pkg::FSM_POP: begin
        pend_valid_d = 1'b1;
        pend_stat_d  = fbfl_pkg::STAT_OK;
        pend_idx_d   = fbfl_pkg::IDX_W'(head_q);
        head_d       = ram_rdata;
        count_d      = count_q - 1'b1;
        state_d      = fbfl_pkg::FSM_IDLE;
      end
    endcase
  end

  // failures carry index zero, so the product is zero for them too
  assign prod = {{fbfl_pkg::BSIZE_W{1'b0}}, pend_idx_q} *
                {{fbfl_pkg::IDX_W{1'b0}}, bsize_q};

  always_comb begin
    out_valid_d = out_valid_q;
    if (pend_move) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bsize_q      <= fbfl_pkg::BSIZE_RST;
      bcount_q     <= fbfl_pkg::BCOUNT_RST;
      state_q      <= fbfl_pkg::FSM_IDLE;
      head_q       <= '0;
      count_q      <= '0;
      fresh_q      <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      bsize_q      <= bsize_d;
      bcount_q     <= bcount_d;
      state_q      <= state_d;
      head_q       <= head_d;
      count_q      <= count_d;
      fresh_q      <= fresh_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_stat_q <= pend_stat_d;
    pend_idx_q  <= pend_idx_d;
    if (pend_move) begin
      out_stat_q <= pend_stat_q;
      out_idx_q  <= pend_idx_q;
      out_off_q  <= prod[fbfl_pkg::OFF_W-1:0];
    end
  end

  assign req_i.ready       = req_ready;
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_stat_q;
  assign rsp_o.block_index = out_idx_q;
  assign rsp_o.byte_offset = out_off_q;

endmodule

@@ hw/rtl/fbfl_link_ram.sv @@
// Link memory of the free list: one write port, one read port, registered read.
// No package dependency.
module fbfl_link_ram #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [ADDR_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [ADDR_W-1:0] rdata_o
);

  logic [ADDR_W-1:0] mem [DEPTH];
  logic [ADDR_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/fbfl_checker.sv @@
// Port-level checks for the allocator, attached by the bind at the end of this file.
// Depends on fbfl_pkg, fbfl_req_if and fbfl_rsp_if.
module fbfl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  fbfl_req_if.sink   req_i,
  fbfl_rsp_if.source rsp_o
);

  logic [1:0] inflight_q;
  logic       req_fire;
  logic       rsp_fire;

  assign req_fire = req_i.valid && req_i.ready;
  assign rsp_fire = rsp_o.valid && rsp_o.ready;

  // items accepted whose result has not yet been taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else if (req_fire && !rsp_fire) begin
      inflight_q <= inflight_q + 1'b1;
    end else if (!req_fire && rsp_fire) begin
      inflight_q <= inflight_q - 1'b1;
    end
  end

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.ready |=>
      rsp_o.valid && $stable(rsp_o.status) && $stable(rsp_o.block_index) &&
      $stable(rsp_o.byte_offset))
    else $error("result item changed or dropped while stalled");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && (rsp_o.status != fbfl_pkg::STAT_OK) |->
      (rsp_o.block_index == '0) && (rsp_o.byte_offset == '0))
    else $error("failed allocate carries a nonzero index or offset");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (inflight_q != 2'd0) && (inflight_q != 2'd3))
    else $error("result item without a matching request item");

  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (inflight_q == 2'd2) && !rsp_o.ready |-> !req_i.ready)
    else $error("request taken with result stage and output both full");

endmodule

bind fixed_block_free_list_allocator fbfl_checker u_fbfl_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .req_i  (req_i),
  .rsp_o  (rsp_o)
);
